// ----- rtl/bloom_filter_double_hash_defines.svh -----
// Assertion macros for the bloom filter block.
// No dependencies; included by the top level only.
`ifndef BLOOM_FILTER_DOUBLE_HASH_DEFINES_SVH
`define BLOOM_FILTER_DOUBLE_HASH_DEFINES_SVH
`ifndef SYNTHESIS
`define BFDH_ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("bfdh assertion failed");
`define BFDH_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("bfdh assertion failed");
`else
`define BFDH_ASSERT_IMPLIES(label, clk, rst, a, b)
`define BFDH_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- rtl/bfdh_pkg.sv -----
// Shared types and constants for the bloom filter block.
// No dependencies.
`timescale 1ns / 1ps
package bfdh_pkg;
   localparam int MAX_BUCKETS = 65536;
   localparam int MAX_HASHES  = 16;
   localparam int FILTER_BYTES = (MAX_BUCKETS + 7) / 8;
   localparam int ADDR_W = $clog2(FILTER_BYTES);
   localparam int POS_W  = $clog2(MAX_BUCKETS);
   localparam int M_W    = $clog2(MAX_BUCKETS + 1);
   localparam int K_W    = $clog2(MAX_HASHES + 1);
   localparam int HASH_W = 64;
   localparam int CNT_W  = 32;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_STEPS = HASH_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_COUNT   = CSR_IDX_W'(1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_READ, ST_MODIFY, ST_RESP
   } back_state_type;

   typedef struct packed {
      logic              command;
      logic [HASH_W-1:0] sum;
      logic [HASH_W-1:0] hash_b;
   } entry_type;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [POS_W-1:0] rem;
   } div_rsp_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;
endpackage

// ----- rtl/bloom_filter_double_hash.sv -----
// Top level of the bloom filter: configuration registers, front and back ends.
// Depends on bfdh_pkg, bfdh_front, bfdh_back and the defines header.
`timescale 1ns / 1ps
`include "bloom_filter_double_hash_defines.svh"
// After reset the filter store is cleared to zero, during which items
// queue in the front end but none is processed. Each probe of an item is
// a modulo on the two-bit-a-cycle divider, the sequencer seeing it done,
// then a read of the byte store and, for an insert, a write of it. A result
// that is not taken holds the back end. By default an item has seven probes.
// Items are worked one at a time; two more can wait in the input queue.
module bloom_filter_double_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [63:0] req_hash_a,
   input  logic [63:0] req_hash_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_present,
   output logic [31:0] rsp_items_inserted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bfdh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfdh_pkg::CSR_DATA_W-1:0] csr_wdata
);
   logic [16:0] bucket_count_ff;
   logic [4:0]  hash_count_ff;
   logic [bfdh_pkg::M_W-1:0] eff_buckets;
   logic [bfdh_pkg::K_W-1:0] eff_hashes;
   logic q_valid, q_pop, csr_write;
   bfdh_pkg::entry_type       q_entry;
   bfdh_pkg::back_status_type status;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= 17'd65536;
         hash_count_ff   <= 5'd7;
      end else if (csr_write) begin
         if (csr_index == bfdh_pkg::CSR_BUCKET_COUNT) bucket_count_ff <= csr_wdata[16:0];
         if (csr_index == bfdh_pkg::CSR_HASH_COUNT)   hash_count_ff   <= csr_wdata[4:0];
      end
   end

   always_comb begin
      priority if (bucket_count_ff == 17'd0) eff_buckets = bfdh_pkg::M_W'(1);
      else if (32'(bucket_count_ff) > bfdh_pkg::MAX_BUCKETS)
         eff_buckets = bfdh_pkg::M_W'(bfdh_pkg::MAX_BUCKETS);
      else eff_buckets = bfdh_pkg::M_W'(bucket_count_ff);
      priority if (hash_count_ff == 5'd0) eff_hashes = bfdh_pkg::K_W'(1);
      else if (32'(hash_count_ff) > bfdh_pkg::MAX_HASHES)
         eff_hashes = bfdh_pkg::K_W'(bfdh_pkg::MAX_HASHES);
      else eff_hashes = bfdh_pkg::K_W'(hash_count_ff);
   end

   bfdh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_hash_a  (req_hash_a),
      .req_hash_b  (req_hash_b),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop)
   );

   bfdh_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_entry            (q_entry),
      .q_pop              (q_pop),
      .eff_buckets        (eff_buckets),
      .eff_hashes         (eff_hashes),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_present        (rsp_present),
      .rsp_items_inserted (rsp_items_inserted),
      .status             (status)
   );

   `BFDH_ASSERT_IMPLIES(a_no_rsp_while_clear, clock, reset, status.clearing, !rsp_valid)
   `BFDH_ASSERT_IMPLIES(a_pop_only_idle, clock, reset, q_pop, q_valid && !status.clearing)
   `BFDH_ASSERT_IMPLIES(a_pop_when_free, clock, reset, q_pop, !status.busy)
   `BFDH_ASSERT_NEXT(a_bucket_write, clock, reset, csr_write && csr_index == bfdh_pkg::CSR_BUCKET_COUNT, bucket_count_ff == $past(csr_wdata[16:0]))
endmodule

// ----- rtl/bfdh_front.sv -----
// Front end: accepts items, forms the first probe sum, two-entry queue.
// Depends on bfdh_pkg.
`timescale 1ns / 1ps
module bfdh_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [63:0]         req_hash_a,
   input  logic [63:0]         req_hash_b,
   output logic                q_valid,
   output bfdh_pkg::entry_type q_entry,
   input  logic                q_pop
);
   bfdh_pkg::entry_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff].command <= req_command;
         entry_ff[wr_ptr_ff].sum     <= req_hash_a + req_hash_b;
         entry_ff[wr_ptr_ff].hash_b  <= req_hash_b;
      end
   end
endmodule

// ----- rtl/bfdh_div.sv -----
// Serial modulo unit, two quotient bits a cycle.
// Depends on bfdh_pkg.
`timescale 1ns / 1ps
module bfdh_div (
   input  logic                            clock,
   input  logic                            reset,
   input  bfdh_pkg::div_req_type           div_req,
   input  logic [bfdh_pkg::M_W-1:0]        divisor,
   output bfdh_pkg::div_rsp_type           div_rsp
);
   logic [bfdh_pkg::HASH_W-1:0]    dvd_ff, dvd_in;
   logic [bfdh_pkg::M_W-1:0]       rem_ff, rem_in, mod_ff, r1;
   logic [bfdh_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   function automatic logic [bfdh_pkg::M_W-1:0] div_step(
      input logic [bfdh_pkg::M_W-1:0] r, input logic b, input logic [bfdh_pkg::M_W-1:0] m);
      logic [bfdh_pkg::M_W:0] t;
      t = {r, b};
      if (t >= {1'b0, m}) t = t - {1'b0, m};
      return t[bfdh_pkg::M_W-1:0];
   endfunction

   always_comb begin
      r1      = div_step(rem_ff, dvd_ff[bfdh_pkg::HASH_W-1], mod_ff);
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = div_step(r1, dvd_ff[bfdh_pkg::HASH_W-2], mod_ff);
         dvd_in = dvd_ff << 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bfdh_pkg::DIV_CNT_W'(bfdh_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (div_req.start) mod_ff <= divisor;
   end

   // remainder is below the modulus, so it fits the probe width
   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff[bfdh_pkg::POS_W-1:0];
endmodule

// ----- rtl/bfdh_back.sv -----
// Back end: probe sequencer, filter bit store, insert counter, result register.
// Depends on bfdh_pkg and bfdh_div.
`timescale 1ns / 1ps
module bfdh_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  bfdh_pkg::entry_type          q_entry,
   output logic                         q_pop,
   input  logic [bfdh_pkg::M_W-1:0]     eff_buckets,
   input  logic [bfdh_pkg::K_W-1:0]     eff_hashes,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_present,
   output logic [31:0]                  rsp_items_inserted,
   output bfdh_pkg::back_status_type    status
);
   bfdh_pkg::back_state_type state_ff, state_in;
   bfdh_pkg::div_req_type    div_req;
   bfdh_pkg::div_rsp_type    div_rsp;

   logic [7:0] mem [bfdh_pkg::FILTER_BYTES];
   logic [7:0] rd_data_ff;
   logic [bfdh_pkg::ADDR_W-1:0] clr_cnt_ff;
   logic [bfdh_pkg::POS_W-1:0]  pos_ff;
   logic [bfdh_pkg::K_W-1:0]    probe_ff;
   logic [bfdh_pkg::HASH_W-1:0] hb_ff;
   logic [bfdh_pkg::CNT_W-1:0]  counter_ff, counter_in;
   logic cmd_ff, all_set_ff, all_set_in, rsp_valid_ff, rsp_present_ff;
   logic [31:0] rsp_count_ff;
   logic mem_we, mem_re, last_probe, rsp_load, bit_hit;
   logic [bfdh_pkg::ADDR_W-1:0] mem_addr;
   logic [7:0] mask, mem_wdata;

   bfdh_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .divisor (eff_buckets),
      .div_rsp (div_rsp)
   );

   assign mask       = 8'(1) << pos_ff[2:0];
   assign bit_hit    = (rd_data_ff & mask) != 8'd0;
   assign last_probe = (probe_ff + 1'b1) == eff_hashes;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfdh_pkg::ST_CLEAR:
            if (clr_cnt_ff == bfdh_pkg::ADDR_W'(bfdh_pkg::FILTER_BYTES - 1))
               state_in = bfdh_pkg::ST_IDLE;
         bfdh_pkg::ST_IDLE:   if (q_valid) state_in = bfdh_pkg::ST_DIV;
         bfdh_pkg::ST_DIV:    if (div_rsp.done) state_in = bfdh_pkg::ST_READ;
         bfdh_pkg::ST_READ:   state_in = bfdh_pkg::ST_MODIFY;
         bfdh_pkg::ST_MODIFY: state_in = last_probe ? bfdh_pkg::ST_RESP : bfdh_pkg::ST_DIV;
         bfdh_pkg::ST_RESP:   if (!rsp_valid_ff || rsp_ready) state_in = bfdh_pkg::ST_IDLE;
         default:             state_in = bfdh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = q_entry.sum;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      mem_addr         = pos_ff[bfdh_pkg::POS_W-1:3];
      mem_wdata        = rd_data_ff | mask;
      rsp_load         = 1'b0;
      unique case (state_ff)
         bfdh_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_ff;
            mem_wdata = 8'd0;
         end
         bfdh_pkg::ST_IDLE: begin
            q_pop         = q_valid;
            div_req.start = q_valid;
         end
         bfdh_pkg::ST_DIV:    ;
         bfdh_pkg::ST_READ:   mem_re = 1'b1;
         bfdh_pkg::ST_MODIFY: begin
            mem_we           = (cmd_ff == bfdh_pkg::CMD_INSERT);
            div_req.start    = !last_probe;
            div_req.dividend = {{(bfdh_pkg::HASH_W-bfdh_pkg::POS_W){1'b0}}, pos_ff} + hb_ff;
         end
         bfdh_pkg::ST_RESP:   rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_comb begin
      all_set_in = all_set_ff;
      if (state_ff == bfdh_pkg::ST_MODIFY && !bit_hit) all_set_in = 1'b0;
      counter_in = counter_ff;
      if (rsp_load && cmd_ff == bfdh_pkg::CMD_INSERT && counter_ff != '1)
         counter_in = counter_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfdh_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         counter_ff <= counter_in;
         if (state_ff == bfdh_pkg::ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      all_set_ff <= all_set_in;
      if (q_pop) begin
         cmd_ff     <= q_entry.command;
         hb_ff      <= q_entry.hash_b;
         probe_ff   <= '0;
         all_set_ff <= 1'b1;
      end
      if (state_ff == bfdh_pkg::ST_DIV && div_rsp.done) pos_ff <= div_rsp.rem;
      if (state_ff == bfdh_pkg::ST_MODIFY) probe_ff <= probe_ff + 1'b1;
      if (rsp_load) begin
         rsp_present_ff <= (cmd_ff == bfdh_pkg::CMD_LOOKUP) && all_set_ff;
         rsp_count_ff   <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_present        = rsp_present_ff;
   assign rsp_items_inserted = rsp_count_ff;
   assign status.clearing    = (state_ff == bfdh_pkg::ST_CLEAR);
   assign status.busy        = (state_ff != bfdh_pkg::ST_IDLE);
endmodule
